### sv/piu_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the priority interrupt unit.
// Depends on nothing; every other file uses it by scoped names.
package piu_pkg;

  // Number of interrupt sources; source 0 has the highest priority
  localparam int NUM_SOURCES = 5;

  // Field widths of the channel words
  localparam int MODE_W = 4;
  localparam int REQ_W  = 5;
  localparam int BUS_W  = 16;
  localparam int RBUS_W = 11;
  localparam int VEC_W  = 3;

  // Vector address base, octal 2000
  localparam logic [RBUS_W-1:0] VEC_BASE = RBUS_W'(11'o2000);

  // Control pulse codes
  typedef enum logic [MODE_W-1:0] {
    MODE_NONE   = 4'd0,
    MODE_RRPA   = 4'd1,
    MODE_GENRST = 4'd2,
    MODE_RPT    = 4'd3,
    MODE_KRPT   = 4'd4,
    MODE_CLRP   = 4'd5,
    MODE_WOVI   = 4'd6,
    MODE_CLINH1 = 4'd7,
    MODE_INH    = 4'd8,
    MODE_CLINH  = 4'd9
  } mode_t;

  // One input word as held in the input register
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [REQ_W-1:0]  new_requests;
    logic [BUS_W-1:0]  write_bus;
  } in_item_t;

  // Input register to core: held word and its valid flag
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

endpackage

### sv/piu_in_if.sv
`timescale 1ns / 1ps
// Input channel of the priority interrupt unit: valid/ready plus the pulse word.
// Depends on piu_pkg for field widths.
interface piu_in_if;
  logic                        valid;
  logic                        ready;
  logic [piu_pkg::MODE_W-1:0]  mode;
  logic [piu_pkg::REQ_W-1:0]   new_requests;
  logic [piu_pkg::BUS_W-1:0]   write_bus;

  modport source (output valid, output mode, output new_requests, output write_bus,
                  input ready);
  modport sink   (input valid, input mode, input new_requests, input write_bus,
                  output ready);
endinterface

### sv/piu_out_if.sv
`timescale 1ns / 1ps
// Result channel of the priority interrupt unit: valid/ready plus the status word.
// Depends on piu_pkg for field widths.
interface piu_out_if;
  logic                        valid;
  logic                        ready;
  logic                        irq;
  logic [piu_pkg::RBUS_W-1:0]  read_bus;
  logic [piu_pkg::VEC_W-1:0]   vector;
  logic [piu_pkg::REQ_W-1:0]   pending;

  modport source (output valid, output irq, output read_bus, output vector,
                  output pending, input ready);
  modport sink   (input valid, input irq, input read_bus, input vector,
                  input pending, output ready);
endinterface

### sv/piu_in_stage.sv
`timescale 1ns / 1ps
// Input register of the priority interrupt unit.
// Depends on piu_pkg and piu_in_if.
module piu_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  piu_in_if.sink          in_word,
  input  logic            take,
  output piu_pkg::stage_t stage
);

  logic              valid_r;
  logic              valid_nxt;
  piu_pkg::in_item_t item_r;
  logic              accept;

  // Accept a word when the register is empty or drains this cycle
  assign in_word.ready = !valid_r || take;
  assign accept        = in_word.valid && in_word.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold the payload; no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.mode         <= in_word.mode;
      item_r.new_requests <= in_word.new_requests;
      item_r.write_bus    <= in_word.write_bus;
    end
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

endmodule

### sv/piu_core.sv
`timescale 1ns / 1ps
// Interrupt state, control pulse logic and result register.
// Depends on piu_pkg and piu_out_if.
module piu_core (
  input  logic            clk,
  input  logic            rst_n,
  input  piu_pkg::stage_t stage,
  output logic            take,
  piu_out_if.source       out_word
);

  localparam int SRC_N = piu_pkg::NUM_SOURCES;
  localparam int REQ_N = piu_pkg::REQ_W;
  localparam int VEC_N = piu_pkg::VEC_W;

  logic [SRC_N-1:0]            pending_r, pending_nxt;
  logic [VEC_N-1:0]            vector_r, vector_nxt;
  logic                        inh_one_r, inh_one_nxt;
  logic                        inh_all_r, inh_all_nxt;
  logic [piu_pkg::RBUS_W-1:0]  rbus_nxt;
  logic                        irq_nxt;

  logic                        out_valid_r;
  logic                        out_irq_r;
  logic [piu_pkg::RBUS_W-1:0]  out_rbus_r;
  logic [VEC_N-1:0]            out_vector_r;
  logic [REQ_N-1:0]            out_pending_r;

  logic [REQ_N+SRC_N-1:0]      req_ext;
  logic [SRC_N+REQ_N-1:0]      pend_ext;
  logic [SRC_N-1:0]            merged;
  logic                        ovf;

  // Lowest-numbered pending source as vector 1..N, zero when none
  function automatic logic [VEC_N-1:0] top_request(input logic [SRC_N-1:0] p);
    logic [VEC_N-1:0] r;
    r = '0;
    for (int i = SRC_N - 1; i >= 0; i--) begin
      if (p[i]) begin
        r = VEC_N'(i + 1);
      end
    end
    return r;
  endfunction

  // Advance when the result register is empty or being read
  assign take = stage.valid && (!out_valid_r || out_word.ready);

  // Keep only requests of sources that exist
  assign req_ext = {{SRC_N{1'b0}}, stage.item.new_requests};
  assign merged  = pending_r | req_ext[SRC_N-1:0];
  assign ovf     = stage.item.write_bus[piu_pkg::BUS_W-1] ^
                   stage.item.write_bus[piu_pkg::BUS_W-2];

  // Perform one control pulse
  always_comb begin
    pending_nxt = merged;
    vector_nxt  = vector_r;
    inh_one_nxt = inh_one_r;
    inh_all_nxt = inh_all_r;
    rbus_nxt    = '0;
    case (stage.item.mode)
      piu_pkg::MODE_RRPA: begin
        rbus_nxt = piu_pkg::VEC_BASE + piu_pkg::RBUS_W'({vector_r, 2'b00});
      end
      piu_pkg::MODE_GENRST: begin
        vector_nxt  = '0;
        inh_all_nxt = 1'b1;
        pending_nxt = '0;
      end
      piu_pkg::MODE_RPT: begin
        vector_nxt = top_request(merged);
      end
      piu_pkg::MODE_KRPT: begin
        // Drop the serviced flag; no vector latched means nothing to kill
        for (int i = 0; i < SRC_N; i++) begin
          if (vector_r == VEC_N'(i + 1)) begin
            pending_nxt[i] = 1'b0;
          end
        end
      end
      piu_pkg::MODE_CLRP: begin
        vector_nxt = '0;
      end
      piu_pkg::MODE_WOVI: begin
        if (ovf) begin
          inh_one_nxt = 1'b1;
        end
      end
      piu_pkg::MODE_CLINH1: begin
        inh_one_nxt = 1'b0;
      end
      piu_pkg::MODE_INH: begin
        inh_all_nxt = 1'b1;
      end
      piu_pkg::MODE_CLINH: begin
        inh_all_nxt = 1'b0;
      end
      default: begin
      end
    endcase
    irq_nxt = (|pending_nxt) && (vector_nxt == '0) && !inh_one_nxt && !inh_all_nxt;
  end

  assign pend_ext = {{REQ_N{1'b0}}, pending_nxt};

  // Update state when a word moves through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      vector_r  <= '0;
      inh_one_r <= 1'b0;
      inh_all_r <= 1'b0;
    end else if (take) begin
      pending_r <= pending_nxt;
      vector_r  <= vector_nxt;
      inh_one_r <= inh_one_nxt;
      inh_all_r <= inh_all_nxt;
    end
  end

  // Result valid: set on take, clear once read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_word.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Hold the result word
  always_ff @(posedge clk) begin
    if (take) begin
      out_irq_r     <= irq_nxt;
      out_rbus_r    <= rbus_nxt;
      out_vector_r  <= vector_nxt;
      out_pending_r <= pend_ext[REQ_N-1:0];
    end
  end

  assign out_word.valid    = out_valid_r;
  assign out_word.irq      = out_irq_r;
  assign out_word.read_bus = out_rbus_r;
  assign out_word.vector   = out_vector_r;
  assign out_word.pending  = out_pending_r;

endmodule

### sv/priority_interrupt_unit.sv
`timescale 1ns / 1ps
// Priority interrupt unit: five pending request flags, a latched vector,
// a one-instruction inhibit and a global inhibit.
//
// Channels: in_word carries one control pulse word (mode, new_requests,
// write_bus); out_word returns one status word per input word (irq,
// read_bus, vector, pending). Both use valid/ready; a word moves at a
// rising edge with valid and ready high.
// Path: an accepted word waits in the input register, then its result in the result register.
// Throughput: one word per cycle while out_word.ready is high; the input register
// and the result register let a new word enter while the previous result waits.
// Stall: while out_word.ready is low the result holds, the input register
// fills, and in_word.ready drops once it is full. Interrupt state changes
// only when a word moves into the result register.
// Reset: rst_n low at a clock edge clears the pending flags, vector,
// both inhibits and both registers' valid flags.
// Depends on piu_pkg, piu_in_if, piu_out_if, piu_in_stage and piu_core.
module priority_interrupt_unit (
  input  logic      clk,
  input  logic      rst_n,
  piu_in_if.sink    in_word,
  piu_out_if.source out_word
);

  piu_pkg::stage_t stage;
  logic            take;

  // Input register
  piu_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_word (in_word),
    .take    (take),
    .stage   (stage)
  );

  // State, pulse logic and result register
  piu_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .stage    (stage),
    .take     (take),
    .out_word (out_word)
  );

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the priority interrupt unit: directed and random pulse
// words, random idling on both channels, an in-bench predictor of the status words.
// Depends on piu_pkg, piu_in_if, piu_out_if and priority_interrupt_unit.
module tb;

  // Field widths and source count of the channel words
  localparam int MODE_W      = piu_pkg::MODE_W;
  localparam int REQ_W       = piu_pkg::REQ_W;
  localparam int BUS_W       = piu_pkg::BUS_W;
  localparam int RBUS_W      = piu_pkg::RBUS_W;
  localparam int VEC_W       = piu_pkg::VEC_W;
  localparam int NUM_SOURCES = piu_pkg::NUM_SOURCES;

  // Mode codes that the unit treats as no pulse
  localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 4'd10;
  localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 4'd15;

  localparam int NUM_WORDS       = 1900;
  localparam int STALL_LIMIT     = 5000;
  localparam int DRAIN_CYCLES    = 4;

  typedef struct packed {
    logic              irq;
    logic [RBUS_W-1:0] read_bus;
    logic [VEC_W-1:0]  vector;
    logic [REQ_W-1:0]  pending;
  } status_word_t;

  logic clk;
  logic rst_n;

  piu_in_if  in_word ();
  piu_out_if out_word ();

  priority_interrupt_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .out_word (out_word)
  );

  piu_pkg::in_item_t pulse_words_q[$];
  status_word_t      expected_status_q[$];

  // Predicted interrupt state
  logic [REQ_W-1:0] model_pending;
  logic [VEC_W-1:0] model_vector;
  logic             model_inh_one;
  logic             model_inh_all;

  int sender_idle_pct;
  int receiver_stall_pct;
  int mismatch_count;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Highest-priority pending source as a vector number, 0 when none
  function automatic logic [VEC_W-1:0] highest_request(input logic [REQ_W-1:0] flags);
    logic [VEC_W-1:0] found;
    found = '0;
    for (int i = NUM_SOURCES - 1; i >= 0; i--) begin
      if (flags[i]) found = VEC_W'(i + 1);
    end
    return found;
  endfunction

  // Apply one pulse word to the predicted state and form its status word
  task automatic predict_status(input piu_pkg::in_item_t word, output status_word_t status);
    status.read_bus = '0;
    model_pending = model_pending | word.new_requests;
    case (word.mode)
      piu_pkg::MODE_RRPA: begin
        status.read_bus = piu_pkg::VEC_BASE + RBUS_W'({model_vector, 2'b00});
      end
      piu_pkg::MODE_GENRST: begin
        model_vector  = '0;
        model_inh_all = 1'b1;
        model_pending = '0;
      end
      piu_pkg::MODE_RPT: begin
        model_vector = highest_request(model_pending);
      end
      piu_pkg::MODE_KRPT: begin
        if (model_vector >= 1 && model_vector <= NUM_SOURCES)
          model_pending[model_vector - 1] = 1'b0;
      end
      piu_pkg::MODE_CLRP:   model_vector = '0;
      piu_pkg::MODE_WOVI: begin
        if (word.write_bus[BUS_W-1] != word.write_bus[BUS_W-2]) model_inh_one = 1'b1;
      end
      piu_pkg::MODE_CLINH1: model_inh_one = 1'b0;
      piu_pkg::MODE_INH:    model_inh_all = 1'b1;
      piu_pkg::MODE_CLINH:  model_inh_all = 1'b0;
      default: ;
    endcase
    status.irq     = (model_pending != '0) && (model_vector == '0) &&
                     !model_inh_one && !model_inh_all;
    status.vector  = model_vector;
    status.pending = model_pending;
  endtask

  task automatic check_field(input string field, input logic [15:0] expected_value,
                             input logic [15:0] actual_value);
    if (actual_value !== expected_value) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field,
               expected_value, actual_value);
      mismatch_count++;
    end
  endtask

  task automatic queue_word(input logic [MODE_W-1:0] mode, input logic [REQ_W-1:0] reqs,
                            input logic [BUS_W-1:0] wbus);
    piu_pkg::in_item_t word;
    word.mode         = mode;
    word.new_requests = reqs;
    word.write_bus    = wbus;
    pulse_words_q.push_back(word);
  endtask

  // Mostly quiet request lines so that pending flags do not saturate
  function automatic logic [REQ_W-1:0] sparse_requests();
    logic [REQ_W-1:0] reqs;
    case ($urandom_range(7))
      5:       reqs = REQ_W'(1) << $urandom_range(REQ_W - 1);
      6:       reqs = REQ_W'($urandom_range(31));
      default: reqs = '0;
    endcase
    return reqs;
  endfunction

  // Queue one servicing sequence with random content; return its length
  task automatic queue_service_sequence(output int count);
    logic [MODE_W-1:0] lead_mode;
    count = 0;
    case ($urandom_range(3))
      0:       lead_mode = piu_pkg::MODE_CLINH;
      1:       lead_mode = piu_pkg::MODE_CLINH1;
      default: lead_mode = piu_pkg::MODE_NONE;
    endcase
    queue_word(lead_mode, sparse_requests() | REQ_W'($urandom_range(31)), 16'($urandom));
    count++;
    if ($urandom_range(3) == 0) begin
      queue_word(piu_pkg::MODE_WOVI, sparse_requests(), 16'($urandom_range(65535)));
      queue_word(piu_pkg::MODE_NONE, sparse_requests(), 16'($urandom));
      queue_word(piu_pkg::MODE_CLINH1, sparse_requests(), 16'($urandom));
      count += 3;
    end
    queue_word(piu_pkg::MODE_RPT, sparse_requests(), 16'($urandom));
    queue_word(piu_pkg::MODE_RRPA, sparse_requests(), 16'($urandom));
    queue_word(piu_pkg::MODE_KRPT, sparse_requests(), 16'($urandom));
    queue_word(piu_pkg::MODE_CLRP, sparse_requests(), 16'($urandom));
    count += 4;
  endtask

  task automatic queue_random_phase(input int target);
    int queued;
    int seq_len;
    queued = 0;
    while (queued < target) begin
      if ($urandom_range(9) < 7) begin
        queue_service_sequence(seq_len);
        queued += seq_len;
      end else begin
        queue_word(MODE_W'($urandom_range(15)), REQ_W'($urandom_range(31)),
                   16'($urandom_range(65535)));
        queued++;
      end
    end
  endtask

  task automatic wait_words_sent();
    while (pulse_words_q.size() != 0 || in_word.valid) @(posedge clk);
  endtask

  // Directed words: priority extremes, every pulse, overflow cases, spare codes
  task automatic queue_directed();
    queue_word(piu_pkg::MODE_NONE, '0, '0);
    queue_word(piu_pkg::MODE_RRPA, '0, '0);
    queue_word(piu_pkg::MODE_NONE, 5'b11111, 16'hFFFF);
    queue_word(piu_pkg::MODE_RPT, '0, '0);
    queue_word(piu_pkg::MODE_RRPA, '0, '0);
    queue_word(piu_pkg::MODE_KRPT, '0, '0);
    queue_word(piu_pkg::MODE_CLRP, '0, '0);
    queue_word(piu_pkg::MODE_GENRST, 5'b10101, '0);
    queue_word(piu_pkg::MODE_CLINH, 5'b10000, '0);
    queue_word(piu_pkg::MODE_RPT, '0, '0);
    queue_word(piu_pkg::MODE_RRPA, '0, '0);
    queue_word(piu_pkg::MODE_KRPT, '0, '0);
    queue_word(piu_pkg::MODE_RPT, '0, '0);
    queue_word(piu_pkg::MODE_KRPT, 5'b01000, '0);
    queue_word(piu_pkg::MODE_WOVI, '0, 16'h8000);
    queue_word(piu_pkg::MODE_CLINH1, '0, '0);
    queue_word(piu_pkg::MODE_WOVI, '0, 16'hC000);
    queue_word(piu_pkg::MODE_WOVI, '0, 16'h0000);
    queue_word(piu_pkg::MODE_WOVI, '0, 16'h7FFF);
    queue_word(piu_pkg::MODE_CLINH1, '0, '0);
    queue_word(piu_pkg::MODE_INH, '0, '0);
    queue_word(piu_pkg::MODE_CLINH, '0, '0);
    for (logic [MODE_W:0] code = MODE_SPARE_FIRST; code <= MODE_SPARE_LAST; code++)
      queue_word(code[MODE_W-1:0], REQ_W'(code), '0);
  endtask

  // Stimulus: directed part, then three idling phases of random words
  initial begin
    rst_n                 = 1'b0;
    in_word.valid         = 1'b0;
    in_word.mode          = piu_pkg::MODE_NONE;
    in_word.new_requests  = '0;
    in_word.write_bus     = '0;
    out_word.ready        = 1'b0;
    model_pending         = '0;
    model_vector          = '0;
    model_inh_one         = 1'b0;
    model_inh_all         = 1'b0;
    mismatch_count        = 0;
    sender_idle_pct       = 8;
    receiver_stall_pct    = 71;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    queue_directed();
    queue_random_phase(NUM_WORDS / 3);
    wait_words_sent();
    sender_idle_pct    = 71;
    receiver_stall_pct = 8;
    queue_random_phase(NUM_WORDS / 3);
    wait_words_sent();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    queue_random_phase(NUM_WORDS / 3);
    wait_words_sent();

    while (expected_status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Drive pulse words; predict the status of each accepted word
  always @(posedge clk) begin : drive_words
    piu_pkg::in_item_t accepted;
    piu_pkg::in_item_t next_word;
    status_word_t      predicted;
    if (!rst_n) begin
      in_word.valid <= 1'b0;
    end else begin
      if (in_word.valid && in_word.ready) begin
        accepted.mode         = in_word.mode;
        accepted.new_requests = in_word.new_requests;
        accepted.write_bus    = in_word.write_bus;
        predict_status(accepted, predicted);
        expected_status_q.push_back(predicted);
      end
      if (!in_word.valid || in_word.ready) begin
        if (pulse_words_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_word = pulse_words_q.pop_front();
          in_word.valid        <= 1'b1;
          in_word.mode         <= next_word.mode;
          in_word.new_requests <= next_word.new_requests;
          in_word.write_bus    <= next_word.write_bus;
        end else begin
          in_word.valid <= 1'b0;
        end
      end
    end
  end

  // Stall the result channel at random and check each accepted status word
  always @(posedge clk) begin : check_status
    status_word_t expected;
    if (!rst_n) begin
      out_word.ready <= 1'b0;
    end else begin
      out_word.ready <= ($urandom_range(99) >= receiver_stall_pct);
      if (out_word.valid && out_word.ready) begin
        if (expected_status_q.size() == 0) begin
          $display("%0t: status word with none expected, expected nothing, got %0d/%0d/%0d/%0d",
                   $time, out_word.irq, out_word.read_bus, out_word.vector, out_word.pending);
          mismatch_count++;
        end else begin
          expected = expected_status_q.pop_front();
          check_field("irq", 16'(expected.irq), 16'(out_word.irq));
          check_field("read_bus", 16'(expected.read_bus), 16'(out_word.read_bus));
          check_field("vector", 16'(expected.vector), 16'(out_word.vector));
          check_field("pending", 16'(expected.pending), 16'(out_word.pending));
        end
      end
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_word.valid && in_word.ready) || (out_word.valid && out_word.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

endmodule
